// File: hdl/arpc_pkg.sv
// Shared types and constants of the ARP responder and address cache.
// Used by the top level and by its port checker; depends on nothing else.
package arpc_pkg;

  localparam int CACHE_ENTRIES = 128;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [10:0] MIN_LEN     = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  HW_LEN      = 8'd6;
  localparam logic [7:0]  PROTO_LEN   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;
  localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

  localparam logic REQ_MESSAGE = 1'b0;
  localparam logic REQ_LOOKUP  = 1'b1;

  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  typedef enum logic [2:0] {
    OUT_IGNORED = 3'd0,
    OUT_REPLY   = 3'd1,
    OUT_CACHED  = 3'd2,
    OUT_FULL    = 3'd3,
    OUT_HIT     = 3'd4,
    OUT_MISS    = 3'd5
  } outcome_t;

  typedef struct packed {
    logic        req_type;
    logic [10:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] operation;
    logic [47:0] sender_hw;
    logic [31:0] sender_proto;
    logic [31:0] target_proto;
    logic [31:0] query_ip;
  } arp_req_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [47:0] reply_target_hw;
    logic [31:0] reply_target_proto;
    logic [47:0] reply_sender_hw;
    logic [31:0] reply_sender_proto;
    logic [47:0] resolved_mac;
  } arp_rsp_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } cache_entry_t;

endpackage

// File: hdl/arp_responder_and_cache.sv
// Top level of the ARP responder and address cache.
// Depends on arpc_pkg for the request, response and cache entry types.
//
// Usage:
// - The request channel (req_valid, req_ready, req) carries either a decoded
//   ARP message or a cache lookup query; each request gives one response.
// - The response channel (rsp_valid, rsp_ready, rsp) holds a result in an
//   output register until the receiver takes it.
// - The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes own_ip (index 0) or own_mac (index 1); it is always ready.
// - The cache is one synchronous memory of address pairs with a registered
//   read port. A lookup reads one entry per cycle in stored order until it
//   finds a match or has read the last stored entry; an empty cache is
//   not read.
// - One request is processed at a time. A new request is taken while the
//   previous response still waits; a finished result waits in its own
//   state until the output register is free, so a stalled receiver stalls
//   intake.
// - Reset empties the cache and clears both configuration registers; the
//   memory contents are not cleared.
module arp_responder_and_cache
  import arpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  arp_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output arp_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PUSH
  } state_t;

  state_t       state;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] idx;
  logic [31:0]  query_ip;
  logic [31:0]  own_ip;
  logic [47:0]  own_mac;
  arp_rsp_t     res;
  arp_rsp_t     msg_res;

  cache_entry_t mem [CACHE_ENTRIES];
  cache_entry_t rd_data;
  logic         rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic         wr_en;

  logic         req_accept;
  logic         msg_ok;
  logic         cache_full;
  logic         scan_hit;
  logic         scan_last;
  logic [IDX_W-1:0] idx_next;

  assign req_ready  = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign req_accept = req_valid && req_ready;
  assign cache_full = (entry_count == CNT_W'(CACHE_ENTRIES));
  assign scan_hit   = (rd_data.ip == query_ip);
  assign scan_last  = ((CNT_W'(idx) + CNT_W'(1)) == entry_count);
  assign idx_next   = idx + IDX_W'(1);

  assign msg_ok = (req.frame_length >= MIN_LEN) && (req.hw_type == HW_ETHERNET) &&
                  (req.proto_type == PROTO_IPV4) && (req.hw_addr_len == HW_LEN) &&
                  (req.proto_addr_len == PROTO_LEN) && (req.target_proto == own_ip);

  always_comb begin
    msg_res = '0;
    msg_res.outcome = OUT_IGNORED;
    wr_en = 1'b0;
    if (msg_ok && req.operation == OP_REQUEST) begin
      msg_res.outcome            = OUT_REPLY;
      msg_res.reply_target_hw    = req.sender_hw;
      msg_res.reply_target_proto = req.sender_proto;
      msg_res.reply_sender_hw    = own_mac;
      msg_res.reply_sender_proto = own_ip;
    end else if (msg_ok && req.operation == OP_REPLY) begin
      if (cache_full) begin
        msg_res.outcome = OUT_FULL;
      end else begin
        msg_res.outcome = OUT_CACHED;
        wr_en = req_accept && (req.req_type == REQ_MESSAGE);
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_IDLE) begin
      rd_en = req_accept && (req.req_type == REQ_LOOKUP) && (entry_count != '0);
    end else if (state == ST_CHECK) begin
      rd_en   = !scan_hit && !scan_last;
      rd_addr = idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[entry_count[IDX_W-1:0]] <= '{ip: req.sender_proto, mac: req.sender_hw};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        CFG_OWN_MAC: own_mac <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != ST_PUSH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            query_ip <= req.query_ip;
            idx      <= '0;
            if (req.req_type == REQ_LOOKUP) begin
              res   <= '{OUT_MISS, 48'h0, 32'h0, 48'h0, 32'h0, BCAST_MAC};
              state <= (entry_count == '0) ? ST_PUSH : ST_CHECK;
            end else begin
              res   <= msg_res;
              state <= ST_PUSH;
              if (wr_en) begin
                entry_count <= entry_count + CNT_W'(1);
              end
            end
          end
        end
        ST_CHECK: begin
          if (scan_hit) begin
            res   <= '{OUT_HIT, 48'h0, 32'h0, 48'h0, 32'h0, rd_data.mac};
            state <= ST_PUSH;
          end else if (scan_last) begin
            state <= ST_PUSH;
          end else begin
            idx <= idx_next;
          end
        end
        ST_PUSH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/arpc_checker.sv
// Port-level checker for the ARP responder and address cache, with its bind.
// Depends on arpc_pkg and on the port list of arp_responder_and_cache.
module arpc_checker
  import arpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input arp_rsp_t    rsp
);

  // A stalled response keeps its value until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Only one request is in progress, so intake closes after each request.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_reply_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome != OUT_REPLY |->
      rsp.reply_target_hw == '0 && rsp.reply_target_proto == '0 &&
      rsp.reply_sender_hw == '0 && rsp.reply_sender_proto == '0)
    else $error("reply fields set on a response that is not a reply");

  a_resolved: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome != OUT_HIT |->
      (rsp.outcome == OUT_MISS && rsp.resolved_mac == BCAST_MAC) ||
      (rsp.outcome != OUT_MISS && rsp.resolved_mac == '0))
    else $error("resolved MAC does not match the outcome");

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (.*);
